### sv/sawtc_pkg.sv
package sawtc_pkg;

    localparam int WAYS       = 4;
    localparam int SETS       = 64;
    localparam int LINE_WORDS = 8;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SETB   = $clog2(SETS);
    localparam int SET_W  = (SETS > 1) ? SETB : 1;
    localparam int TAG_W  = 32 - 5 - SETB;
    localparam int NLINES = WAYS * SETS;
    localparam int LINE_W = $clog2(NLINES) > 0 ? $clog2(NLINES) : 1;
    localparam int WORD_AW = LINE_W + 3;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REFILL = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WAIT,
        ST_FILL_RD,
        ST_FILL_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] data;
    } req_t;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
        logic [26:0] s;
        begin
            s = a[31:5];
            set_of = SET_W'(s & 27'(SETS - 1));
        end
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
        begin
            tag_of = TAG_W'(a >> (5 + SETB));
        end
    endfunction

endpackage

### sv/sawtc_ram.sv
module sawtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sawtc_front.sv
// Accepts one beat, classifies it and holds it in a one-entry queue for the back end.
module sawtc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       opcode,
    input  logic [31:0]      address,
    input  logic [31:0]      data_in,
    input  logic             fill_pending,
    input  logic             back_take,
    output logic             q_valid,
    output sawtc_pkg::req_t  q_req,
    output logic             busy
);

    logic            q_valid_reg, q_valid_next;
    sawtc_pkg::req_t q_req_reg;
    logic            keep;

    // Requests during a fill, stray refills and unused opcodes are dropped here.
    always_comb
    begin
        case (sawtc_pkg::op_t'(opcode))
            sawtc_pkg::OP_READ, sawtc_pkg::OP_WRITE: keep = !fill_pending;
            sawtc_pkg::OP_REFILL:                    keep = fill_pending;
            default:                                 keep = 1'b0;
        endcase
    end

    assign busy = q_valid_reg;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (back_take)
        begin
            q_valid_next = 1'b0;
        end
        if (start && !busy && keep)
        begin
            q_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            q_req_reg <= '{op: opcode, addr: address, data: data_in};
        end
    end

    assign q_valid = q_valid_reg;
    assign q_req   = q_req_reg;

endmodule

### sv/sawtc_back.sv
// Tag lookup, LRU choice, line store access and result generation.
module sawtc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sawtc_pkg::req_t q_req,
    output logic            back_take,
    output logic            fill_pending,
    output logic            strobe,
    output logic [1:0]      kind,
    output logic [31:0]     out_address,
    output logic [31:0]     out_data,
    output logic            hit
);

    localparam int WAYS  = sawtc_pkg::WAYS;
    localparam int WAY_W = sawtc_pkg::WAY_W;
    localparam int SET_W = sawtc_pkg::SET_W;
    localparam int TAG_W = sawtc_pkg::TAG_W;
    localparam int LINE_W = sawtc_pkg::LINE_W;
    localparam int WORD_AW = sawtc_pkg::WORD_AW;

    sawtc_pkg::state_t state_reg, state_next;

    logic [WAYS-1:0]  valid_reg [sawtc_pkg::SETS];
    logic [WAYS-1:0]  valid_set_reg;
    logic             fill_pending_reg, fill_pending_next;
    logic [31:0]      fill_address_reg;
    logic [2:0]       fill_count_reg, fill_count_next;
    logic [WAY_W-1:0] victim_reg;
    logic             hit_reg;

    logic             strobe_reg;
    logic [1:0]       kind_reg;
    logic [31:0]      oaddr_reg, odata_reg;
    logic             ohit_reg;

    // One tag and one stamp RAM per way, one set clock RAM, one shared word RAM.
    logic [TAG_W-1:0] tag_rd [WAYS];
    logic [31:0]      stamp_rd [WAYS];
    logic [31:0]      stamp_eff [WAYS];
    logic [WAYS-1:0]  tag_we, stamp_we;
    logic [SET_W-1:0] rd_set, wr_set;
    logic [31:0]      stamp_wdata;
    logic [TAG_W-1:0] tag_wdata;
    logic             clock_we;
    logic [31:0]      clock_rd, clock_eff;

    logic             wrd_we;
    logic [WORD_AW-1:0] wrd_waddr, wrd_raddr;
    logic [31:0]      wrd_wdata, wrd_rd;

    logic [31:0]      addr_eff;
    logic [SET_W-1:0] cur_set;
    logic [WAYS-1:0]  match;
    logic             any_hit;
    logic [WAY_W-1:0] match_way, lru_way;

    assign addr_eff = (q_req.op == sawtc_pkg::OP_REFILL) ? fill_address_reg : q_req.addr;
    assign cur_set  = sawtc_pkg::set_of(addr_eff);
    assign rd_set   = cur_set;
    assign clock_we = |stamp_we;

    genvar g;
    generate
        for (g = 0; g < WAYS; g++)
        begin : g_way
            sawtc_ram #(.WIDTH(TAG_W), .DEPTH(sawtc_pkg::SETS)) u_tag (
                .clk(clk), .we(tag_we[g]), .waddr(wr_set), .wdata(tag_wdata),
                .raddr(rd_set), .rdata(tag_rd[g]));
            sawtc_ram #(.WIDTH(32), .DEPTH(sawtc_pkg::SETS)) u_stamp (
                .clk(clk), .we(stamp_we[g]), .waddr(wr_set), .wdata(stamp_wdata),
                .raddr(rd_set), .rdata(stamp_rd[g]));
        end
    endgenerate

    sawtc_ram #(.WIDTH(32), .DEPTH(sawtc_pkg::SETS)) u_clock (
        .clk(clk), .we(clock_we), .waddr(wr_set), .wdata(stamp_wdata),
        .raddr(rd_set), .rdata(clock_rd));

    sawtc_ram #(.WIDTH(32), .DEPTH(sawtc_pkg::NLINES * sawtc_pkg::LINE_WORDS)) u_words (
        .clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
        .raddr(wrd_raddr), .rdata(wrd_rd));

    // A way is only stamped once it holds a line, and valid bits are never cleared
    // after reset, so an invalid way has stamp zero and a set with no valid line
    // still has its clock at zero.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            stamp_eff[w] = valid_set_reg[w] ? stamp_rd[w] : 32'd0;
        end
    end
    assign clock_eff = (|valid_set_reg) ? clock_rd : 32'd0;

    // Hit compare and LRU search on the registered RAM outputs.
    always_comb
    begin
        match     = '0;
        match_way = '0;
        lru_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = valid_set_reg[w] && (tag_rd[w] == sawtc_pkg::tag_of(addr_eff));
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                match_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (stamp_eff[w] < stamp_eff[lru_way])
            begin
                lru_way = WAY_W'(w);
            end
        end
    end
    assign any_hit = |match;

    function automatic logic [LINE_W-1:0] line_idx(input logic [SET_W-1:0] s,
                                                   input logic [WAY_W-1:0] w);
        begin
            line_idx = LINE_W'(s * WAYS + w);
        end
    endfunction

    always_comb
    begin
        state_next        = state_reg;
        back_take         = 1'b0;
        fill_pending_next = fill_pending_reg;
        fill_count_next   = fill_count_reg;
        tag_we            = '0;
        stamp_we          = '0;
        wr_set            = cur_set;
        tag_wdata         = sawtc_pkg::tag_of(addr_eff);
        stamp_wdata       = clock_eff + 32'd1;
        wrd_we            = 1'b0;
        wrd_waddr         = {line_idx(cur_set, victim_reg), fill_count_reg};
        wrd_wdata         = q_req.data;
        wrd_raddr         = {line_idx(cur_set, match_way), q_req.addr[4:2]};
        case (state_reg)
            sawtc_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_req.op == sawtc_pkg::OP_REFILL && fill_count_reg != 3'd0)
                    begin
                        wrd_we = 1'b1;
                        if (fill_count_reg == 3'd7)
                        begin
                            // Last refill word: written now; the requested word of the line is read in ST_FILL_RD.
                            state_next = sawtc_pkg::ST_FILL_RD;
                        end
                        else
                        begin
                            fill_count_next = fill_count_reg + 3'd1;
                            back_take       = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = sawtc_pkg::ST_LOOKUP;
                    end
                end
            end
            sawtc_pkg::ST_LOOKUP:
            begin
                state_next = sawtc_pkg::ST_WAIT;
                if (q_req.op == sawtc_pkg::OP_REFILL)
                begin
                    // First refill word fixes the victim.
                    wrd_waddr       = {line_idx(cur_set, lru_way), 3'd0};
                    wrd_we          = 1'b1;
                    fill_count_next = 3'd1;
                    back_take       = 1'b1;
                    state_next      = sawtc_pkg::ST_IDLE;
                end
                else if (q_req.op == sawtc_pkg::OP_WRITE && any_hit)
                begin
                    wrd_waddr       = {line_idx(cur_set, match_way), q_req.addr[4:2]};
                    wrd_we          = 1'b1;
                    stamp_we[match_way] = 1'b1;
                end
                else if (q_req.op == sawtc_pkg::OP_READ && any_hit)
                begin
                    stamp_we[match_way] = 1'b1;
                end
                else if (q_req.op == sawtc_pkg::OP_READ)
                begin
                    fill_pending_next = 1'b1;
                    fill_count_next   = 3'd0;
                end
            end
            sawtc_pkg::ST_WAIT:
            begin
                back_take  = 1'b1;
                state_next = sawtc_pkg::ST_IDLE;
            end
            sawtc_pkg::ST_FILL_RD:
            begin
                wrd_raddr  = {line_idx(cur_set, victim_reg), fill_address_reg[4:2]};
                tag_we[victim_reg]   = 1'b1;
                stamp_we[victim_reg] = 1'b1;
                state_next = sawtc_pkg::ST_FILL_DONE;
            end
            sawtc_pkg::ST_FILL_DONE:
            begin
                back_take         = 1'b1;
                fill_pending_next = 1'b0;
                fill_count_next   = 3'd0;
                state_next        = sawtc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sawtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sawtc_pkg::ST_IDLE;
            fill_pending_reg <= 1'b0;
            fill_count_reg   <= 3'd0;
            strobe_reg       <= 1'b0;
            for (int s = 0; s < sawtc_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            fill_pending_reg <= fill_pending_next;
            fill_count_reg   <= fill_count_next;
            strobe_reg       <= 1'b0;
            if (|tag_we)
            begin
                valid_reg[cur_set][victim_reg] <= 1'b1;
            end
            if (state_reg == sawtc_pkg::ST_WAIT || state_reg == sawtc_pkg::ST_FILL_DONE)
            begin
                strobe_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        valid_set_reg <= valid_reg[rd_set];
        if (state_reg == sawtc_pkg::ST_LOOKUP)
        begin
            hit_reg <= any_hit;
            if (q_req.op == sawtc_pkg::OP_REFILL)
            begin
                victim_reg <= lru_way;
            end
        end
        if (state_reg == sawtc_pkg::ST_LOOKUP && q_req.op == sawtc_pkg::OP_READ && !any_hit)
        begin
            fill_address_reg <= q_req.addr;
        end
        if (state_reg == sawtc_pkg::ST_WAIT)
        begin
            oaddr_reg <= q_req.addr;
            ohit_reg  <= hit_reg;
            if (q_req.op == sawtc_pkg::OP_WRITE)
            begin
                kind_reg  <= sawtc_pkg::KIND_WRITE;
                odata_reg <= q_req.data;
            end
            else if (hit_reg)
            begin
                kind_reg  <= sawtc_pkg::KIND_READ;
                odata_reg <= wrd_rd;
            end
            else
            begin
                kind_reg  <= sawtc_pkg::KIND_FILL;
                oaddr_reg <= {q_req.addr[31:5], 5'd0};
                odata_reg <= '0;
            end
        end
        if (state_reg == sawtc_pkg::ST_FILL_DONE)
        begin
            kind_reg  <= sawtc_pkg::KIND_READ;
            oaddr_reg <= fill_address_reg;
            odata_reg <= wrd_rd;
            ohit_reg  <= 1'b0;
        end
    end

    assign fill_pending = fill_pending_reg;
    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign out_address  = oaddr_reg;
    assign out_data     = odata_reg;
    assign hit          = ohit_reg;

endmodule

### sv/set_assoc_write_through_cache.sv
// Channel   Direction  Beat marker      Payload
// request   in         start & !busy    opcode, address, data_in
// result    out        strobe           kind, out_address, out_data, hit
//
// A read or write passes through tag and stamp RAM read, compare with LRU pick,
// word RAM read and output register from accept to strobe.
// Refill words are written as taken; after the last, the requested word is read out.
// Reset is asynchronous and clears valid bits and the fill state; stamps and the
// set clock of a set with no valid line read as zero.
// The receiver cannot stall; busy holds requests off while the queue is full.
module set_assoc_write_through_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] address,
    input  logic [31:0] data_in,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [31:0] out_address,
    output logic [31:0] out_data,
    output logic        hit
);

    logic            q_valid, back_take, fill_pending;
    sawtc_pkg::req_t q_req;

    sawtc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(opcode),
        .address(address), .data_in(data_in), .fill_pending(fill_pending),
        .back_take(back_take), .q_valid(q_valid), .q_req(q_req), .busy(busy));

    sawtc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .back_take(back_take), .fill_pending(fill_pending), .strobe(strobe),
        .kind(kind), .out_address(out_address), .out_data(out_data), .hit(hit));

endmodule
